>>> hdl/ldf_pkg.sv
// Package for the length-prefixed frame deframer.
// Types, codes and constants shared by the front, queue, back and top level.
// No dependencies.
package ldf_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_BYTE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_REPEAT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESP_TYPE   = 2'd2;

	localparam logic [7:0]  SYNC_BYTE_RST   = 8'h00;
	localparam logic [3:0]  SYNC_REPEAT_RST = 4'd2;
	localparam logic [15:0] RESP_TYPE_RST   = 16'h0000;
	localparam logic [15:0] MIN_FRAME       = 16'd8;

	typedef enum logic [2:0] {
		KIND_DATA     = 3'd0,
		KIND_DONE     = 3'd1,
		KIND_EMPTY    = 3'd2,
		KIND_NOT_RESP = 3'd3,
		KIND_BAD_LEN  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_LEN  = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0]  sync_byte;
		logic [3:0]  sync_repeat;
		logic [15:0] response_type;
	} cfg_t;

	typedef struct packed {
		logic        data_v;
		logic [7:0]  type_code;
		logic [14:0] word_index;
		logic [15:0] word_value;
		logic        stat_v;
		kind_t       stat_kind;
		logic [14:0] stat_index;
	} event_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

>>> hdl/ldf_if.sv
// Valid/ready channel interfaces for the deframer: received bytes in,
// result items out. No dependencies.
interface ldf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ldf_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  result_kind;
	logic [7:0]  type_code;
	logic [14:0] word_index;
	logic [15:0] word_value;
	logic        last;

	modport source (output valid, output result_kind, output type_code, output word_index,
		output word_value, output last, input ready);
	modport sink   (input valid, input result_kind, input type_code, input word_index,
		input word_value, input last, output ready);
endinterface

>>> hdl/length_prefixed_frame_deframer.sv
// Top level of the length-prefixed frame deframer: config registers, front
// parser, event queue and result back end. Depends on ldf_pkg, ldf_if and submodules.
//
//   channel  dir  payload                                          accepted when
//   in_ch    in   rx_byte                                          valid && ready
//   out_ch   out  result_kind, type_code, word_index, word_value,  valid && ready
//                 last
//   cfg      in   cfg_index, cfg_data                              cfg_we
//
// One byte per cycle enters the front; the byte goes through a single parse stage.
// Each queued record yields one or two results, drained one per cycle by the back
// end unless out_ch stalls, so a final byte holding a word and status yields both.
// Bytes stall only when the QUEUE_DEPTH-entry event queue is full.
// Reset clears parser state and config registers at once; no clearing pass.
module length_prefixed_frame_deframer #(
	parameter int QUEUE_DEPTH = ldf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ldf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ldf_pkg::CFG_DATA_W-1:0]   cfg_data,
	ldf_byte_if.sink                         in_ch,
	ldf_result_if.source                     out_ch
);
	import ldf_pkg::*;

	cfg_t      cfg_q;
	logic      acc;
	logic      push;
	logic      pop;
	event_t    ev;
	event_t    head;
	q_status_t q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_byte     <= SYNC_BYTE_RST;
			cfg_q.sync_repeat   <= SYNC_REPEAT_RST;
			cfg_q.response_type <= RESP_TYPE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SYNC_BYTE:   cfg_q.sync_byte     <= cfg_data[7:0];
				REG_SYNC_REPEAT: cfg_q.sync_repeat   <= cfg_data[3:0];
				REG_RESP_TYPE:   cfg_q.response_type <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign in_ch.ready = !q_stat.full;
	assign acc         = in_ch.valid && in_ch.ready;

	ldf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.acc     (acc),
		.rx_byte (in_ch.rx_byte),
		.push    (push),
		.ev      (ev)
	);

	ldf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_ev  (ev),
		.pop    (pop),
		.head   (head),
		.status (q_stat)
	);

	ldf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.out_ch (out_ch)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !push)
		else $error("event pushed into full queue");

	a_last_on_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.last == (out_ch.result_kind != KIND_DATA)))
		else $error("last does not match result kind");

	a_status_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.last) |-> (out_ch.word_value == '0))
		else $error("status result carries a word value");

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

endmodule

>>> hdl/ldf_front.sv
// Front end: parses one byte per transaction and emits one event record
// per byte that yields results. Depends on ldf_pkg.
module ldf_front (
	input  logic            clk,
	input  logic            arst_n,
	input  ldf_pkg::cfg_t   cfg,
	input  logic            acc,
	input  logic [7:0]      rx_byte,
	output logic            push,
	output ldf_pkg::event_t ev
);
	import ldf_pkg::*;

	phase_t      phase_q, phase_n;
	logic [3:0]  seen_q, seen_n;
	logic [15:0] pos_q, pos_n;
	logic [15:0] len_q, len_n;
	logic [7:0]  held_q, held_n;
	logic [15:0] mtype_q, mtype_n;
	logic [7:0]  plow_q, plow_n;

	logic [3:0]  need;
	logic [3:0]  seen_inc;
	logic [15:0] word;
	logic [14:0] widx;
	logic [15:0] len_minus;
	logic        frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			seen_q  <= '0;
			pos_q   <= '0;
			len_q   <= '0;
			held_q  <= '0;
			mtype_q <= '0;
			plow_q  <= '0;
		end else begin
			phase_q <= phase_n;
			seen_q  <= seen_n;
			pos_q   <= pos_n;
			len_q   <= len_n;
			held_q  <= held_n;
			mtype_q <= mtype_n;
			plow_q  <= plow_n;
		end
	end

	assign need      = (cfg.sync_repeat == 4'd0) ? 4'd1 : cfg.sync_repeat;
	assign seen_inc  = seen_q + 4'd1;
	assign word      = {rx_byte, held_q};
	assign widx      = pos_q[15:1];
	assign len_minus = len_q - MIN_FRAME;
	assign frame_end = ({1'b0, pos_q} + 17'd1) >= {1'b0, len_q};

	always_comb begin
		phase_n = phase_q;
		seen_n  = seen_q;
		pos_n   = pos_q;
		len_n   = len_q;
		held_n  = held_q;
		mtype_n = mtype_q;
		plow_n  = plow_q;
		ev      = '0;
		ev.stat_kind = KIND_DATA;
		if (acc) begin
			unique case (phase_q)
				PH_LEN: begin
					if (pos_q == 16'd0) begin
						held_n = rx_byte;
						pos_n  = 16'd1;
					end else begin
						len_n = word;
						if (word[0] || word < MIN_FRAME) begin
							ev.stat_v    = 1'b1;
							ev.stat_kind = KIND_BAD_LEN;
							phase_n      = PH_HUNT;
							seen_n       = '0;
							pos_n        = '0;
						end else begin
							pos_n   = 16'd2;
							phase_n = PH_BODY;
						end
					end
				end
				PH_BODY: begin
					ev.type_code = plow_q;
					if (!pos_q[0]) begin
						held_n = rx_byte;
					end else if (widx == 15'd1) begin
						mtype_n = word;
					end else if (widx == 15'd2) begin
						plow_n = word[7:0];
					end else if (widx >= 15'd4 && mtype_q == cfg.response_type) begin
						ev.data_v     = 1'b1;
						ev.word_index = widx - 15'd4;
						ev.word_value = word;
					end
					if (frame_end) begin
						ev.stat_v = 1'b1;
						if (mtype_q != cfg.response_type) begin
							ev.stat_kind = KIND_NOT_RESP;
						end else if (len_minus[15:1] == 15'd0) begin
							ev.stat_kind = KIND_EMPTY;
						end else begin
							ev.stat_kind  = KIND_DONE;
							ev.stat_index = len_minus[15:1];
						end
						phase_n = PH_HUNT;
						seen_n  = '0;
						pos_n   = '0;
					end else begin
						pos_n = pos_q + 16'd1;
					end
				end
				default: begin
					phase_n = PH_HUNT;
					if (rx_byte == cfg.sync_byte) begin
						if (seen_inc >= need) begin
							seen_n  = '0;
							pos_n   = '0;
							phase_n = PH_LEN;
						end else begin
							seen_n = seen_inc;
						end
					end else begin
						seen_n = '0;
					end
				end
			endcase
		end
		push = acc && (ev.data_v || ev.stat_v);
	end

endmodule

>>> hdl/ldf_queue.sv
// Event queue between front and back: a small register FIFO.
// Depends on ldf_pkg.
module ldf_queue #(
	parameter int DEPTH = ldf_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ldf_pkg::event_t     wr_ev,
	input  logic                pop,
	output ldf_pkg::event_t     head,
	output ldf_pkg::q_status_t  status
);
	import ldf_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	event_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign status.full  = (cnt_q == FULL_CNT);
	assign status.empty = (cnt_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> hdl/ldf_back.sv
// Back end: expands queued event records into result transactions through
// an output register. Depends on ldf_pkg and ldf_if.
module ldf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  ldf_pkg::event_t     head,
	input  ldf_pkg::q_status_t  q_stat,
	output logic                pop,
	ldf_result_if.source        out_ch
);
	import ldf_pkg::*;

	logic        out_v_q;
	logic        data_done_q;
	logic [2:0]  kind_q;
	logic [7:0]  code_q;
	logic [14:0] index_q;
	logic [15:0] value_q;
	logic        last_q;
	logic        load;
	logic        emit_data;

	assign load      = !q_stat.empty && (!out_v_q || out_ch.ready);
	assign emit_data = head.data_v && !data_done_q;
	assign pop       = load && !(emit_data && head.stat_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q     <= 1'b0;
			data_done_q <= 1'b0;
		end else begin
			if (load) begin
				out_v_q     <= 1'b1;
				data_done_q <= emit_data && head.stat_v;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_q <= head.type_code;
			if (emit_data) begin
				kind_q  <= KIND_DATA;
				index_q <= head.word_index;
				value_q <= head.word_value;
				last_q  <= 1'b0;
			end else begin
				kind_q  <= head.stat_kind;
				index_q <= head.stat_index;
				value_q <= '0;
				last_q  <= 1'b1;
			end
		end
	end

	assign out_ch.valid       = out_v_q;
	assign out_ch.result_kind = kind_q;
	assign out_ch.type_code   = code_q;
	assign out_ch.word_index  = index_q;
	assign out_ch.word_value  = value_q;
	assign out_ch.last        = last_q;

endmodule

>>> test/tb_length_prefixed_frame_deframer.sv
`timescale 1ns / 100ps
// Testbench for length_prefixed_frame_deframer: byte streams of sync runs, frames and
// noise go in, and each result is checked against a built-in frame parser model.
// Depends on ldf_pkg, ldf_if and the deframer RTL.
module tb_length_prefixed_frame_deframer;
	import ldf_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES  = 20;
	localparam int STALL_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 300;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  code;
		logic [14:0] index;
		logic [15:0] value;
		logic        last;
	} result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ldf_byte_if   in_if ();
	ldf_result_if out_if ();

	length_prefixed_frame_deframer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_if),
		.out_ch    (out_if)
	);

	// model of the configuration registers
	logic [7:0]  sync_code;
	logic [3:0]  sync_run_len;
	logic [15:0] resp_code;

	// model of the parser state
	phase_t      parse_phase;
	logic [3:0]  sync_count;
	logic [15:0] frame_pos;
	logic [15:0] frame_length;
	logic [7:0]  low_byte;
	logic [15:0] msg_type;
	logic [7:0]  param_code;

	result_t expected_results[$];
	int      error_count;
	int      byte_count;
	int      stall_cycles;
	int      hold_rx_cycles;
	int      src_idle_pct;
	int      snk_idle_pct;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic void add_expected(kind_t k, logic [7:0] c, logic [14:0] i,
		logic [15:0] v, logic l);
		result_t r;
		r.kind  = k;
		r.code  = c;
		r.index = i;
		r.value = v;
		r.last  = l;
		expected_results.push_back(r);
	endfunction

	function automatic void end_frame();
		parse_phase = PH_HUNT;
		sync_count  = 4'd0;
		frame_pos   = 16'd0;
	endfunction

	task automatic predict_byte(input logic [7:0] b);
		int          pos;
		int          widx;
		int          count;
		int          need;
		logic [15:0] w;
		case (parse_phase)
			PH_LEN: begin
				if (frame_pos == 16'd0) begin
					low_byte  = b;
					frame_pos = 16'd1;
				end else begin
					frame_length = {b, low_byte};
					if (frame_length[0] || frame_length < MIN_FRAME) begin
						add_expected(KIND_BAD_LEN, 8'd0, 15'd0, 16'd0, 1'b1);
						end_frame();
					end else begin
						frame_pos   = 16'd2;
						parse_phase = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				pos = frame_pos;
				if (pos % 2 == 0) begin
					low_byte = b;
				end else begin
					w    = {b, low_byte};
					widx = pos / 2;
					if (widx == 1)
						msg_type = w;
					else if (widx == 2)
						param_code = w[7:0];
					else if (widx >= 4 && msg_type == resp_code)
						add_expected(KIND_DATA, param_code, 15'(widx - 4), w, 1'b0);
				end
				if (pos + 1 >= int'(frame_length)) begin
					count = (int'(frame_length) - int'(MIN_FRAME)) / 2;
					if (msg_type != resp_code)
						add_expected(KIND_NOT_RESP, param_code, 15'd0, 16'd0, 1'b1);
					else if (count == 0)
						add_expected(KIND_EMPTY, param_code, 15'd0, 16'd0, 1'b1);
					else
						add_expected(KIND_DONE, param_code, 15'(count), 16'd0, 1'b1);
					end_frame();
				end else begin
					frame_pos = 16'(pos + 1);
				end
			end
			default: begin
				parse_phase = PH_HUNT;
				if (b == sync_code) begin
					need       = (sync_run_len == 4'd0) ? 1 : int'(sync_run_len);
					sync_count = sync_count + 4'd1;
					if (int'(sync_count) >= need) begin
						sync_count  = 4'd0;
						frame_pos   = 16'd0;
						parse_phase = PH_LEN;
					end
				end else begin
					sync_count = 4'd0;
				end
			end
		endcase
	endtask

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			@(negedge clk);
			in_if.valid <= 1'b0;
		end
		@(negedge clk);
		in_if.valid   <= 1'b1;
		in_if.rx_byte <= b;
		@(posedge clk);
		while (!in_if.ready)
			@(posedge clk);
		byte_count++;
		predict_byte(b);
	endtask

	task automatic send_word(input logic [15:0] w);
		send_byte(w[7:0]);
		send_byte(w[15:8]);
	endtask

	task automatic send_sync();
		repeat ((sync_run_len == 4'd0) ? 1 : int'(sync_run_len))
			send_byte(sync_code);
	endtask

	task automatic send_noise(input int n);
		logic [7:0] b;
		repeat (n) begin
			do
				b = 8'($urandom_range(0, 255));
			while (b == sync_code);
			send_byte(b);
		end
	endtask

	task automatic send_frame(input logic [15:0] mtype, input logic [7:0] param, input int n);
		send_sync();
		send_word(16'(int'(MIN_FRAME) + 2 * n));
		send_word(mtype);
		send_word({8'($urandom), param});
		send_word(16'($urandom));
		repeat (n)
			send_word(16'($urandom));
	endtask

	task automatic send_bad_frame(input logic [15:0] len);
		send_sync();
		send_word(len);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_if.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SYNC_BYTE:   sync_code    = data[7:0];
			REG_SYNC_REPEAT: sync_run_len = data[3:0];
			REG_RESP_TYPE:   resp_code    = data;
			default: ;
		endcase
	endtask

	task automatic test_reset_defaults();
		src_idle_pct = 10;
		snk_idle_pct = 30;
		send_sync();
		send_word(16'd12);
		send_word(16'h0000);
		send_word(16'h12FF);
		send_word(16'hFFFF);
		send_word(16'hFFFF);
		send_word(16'h0000);
		send_frame(16'h0000, 8'h00, 0);
		send_frame(16'h0001, 8'h80, 1);
		// break the sync run, then frame normally
		send_byte(sync_code);
		send_noise(1);
		send_frame(16'h0000, 8'h5A, 1);
	endtask

	task automatic test_bad_length();
		send_bad_frame(16'd7);
		send_bad_frame(16'd6);
		send_bad_frame(16'd0);
		send_bad_frame(16'hFFFF);
		send_bad_frame(16'h8001);
		send_frame(16'h0000, 8'h01, 0);
	endtask

	task automatic test_registers();
		wait_idle();
		write_reg(REG_SYNC_BYTE, 16'h00FF);
		write_reg(REG_SYNC_REPEAT, 16'd8);
		write_reg(REG_RESP_TYPE, 16'hFFFF);
		send_noise(2);
		send_frame(16'hFFFF, 8'h3C, 1);
		send_frame(16'h7FFF, 8'h01, 1);
		send_frame(16'hFFFF, 8'hFE, 0);
		wait_idle();
		// upper data bits are don't-care; repeat count zero acts as one
		write_reg(REG_SYNC_BYTE, 16'hA511);
		write_reg(REG_SYNC_REPEAT, 16'hABC0);
		write_reg(REG_RESP_TYPE, 16'h8001);
		send_frame(16'h8001, 8'h77, 2);
		send_frame(16'h0001, 8'h77, 0);
		wait_idle();
		write_reg(REG_SYNC_BYTE, 16'h0000);
		write_reg(REG_SYNC_REPEAT, 16'd1);
		write_reg(REG_RESP_TYPE, 16'h0000);
		send_frame(16'h0000, 8'hC3, 3);
	endtask

	task automatic test_midframe_config();
		for (int i = 0; i < 2; i++) begin
			wait_idle();
			write_reg(REG_RESP_TYPE, (i == 0) ? 16'h1234 : 16'h4321);
			send_sync();
			send_word(16'd12);
			send_word(16'h1234);
			wait_idle();
			write_reg(REG_RESP_TYPE, (i == 0) ? 16'h4321 : 16'h1234);
			send_word(16'h0077);
			send_word(16'h0000);
			send_word(16'hBEEF);
			send_word(16'hCAFE);
		end
	endtask

	task automatic test_backpressure();
		wait_idle();
		src_idle_pct   = 0;
		snk_idle_pct   = 0;
		hold_rx_cycles = HOLD_CYCLES;
		send_frame(resp_code, 8'h42, 24);
		send_frame(16'(resp_code + 16'd1), 8'h43, 2);
	endtask

	task automatic test_random(input int n_bytes, input int s_pct, input int r_pct);
		int start;
		int sel;
		int n;
		wait_idle();
		src_idle_pct = s_pct;
		snk_idle_pct = r_pct;
		write_reg(REG_SYNC_BYTE, 16'($urandom_range(0, 255)));
		write_reg(REG_SYNC_REPEAT, 16'($urandom_range(0, 8)));
		write_reg(REG_RESP_TYPE, 16'($urandom_range(0, 65535)));
		start = byte_count;
		while (byte_count - start < n_bytes) begin
			sel = $urandom_range(0, 99);
			if (sel < 70) begin
				n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 4);
				send_noise($urandom_range(0, 2));
				send_frame(($urandom_range(0, 99) < 60) ? resp_code : 16'($urandom),
					8'($urandom), n);
			end else if (sel < 85) begin
				if ($urandom_range(0, 1) == 0)
					send_bad_frame(16'($urandom) | 16'h0001);
				else
					send_bad_frame(16'($urandom_range(0, 7)));
			end else if (sel < 95) begin
				repeat ((sync_run_len <= 4'd1) ? 0 : int'(sync_run_len) - 1)
					send_byte(sync_code);
				send_noise(1);
			end else begin
				send_noise($urandom_range(1, 6));
			end
		end
	endtask

	always @(negedge clk) begin
		if (hold_rx_cycles > 0) begin
			out_if.ready   <= 1'b0;
			hold_rx_cycles = hold_rx_cycles - 1;
		end else begin
			out_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_if.valid && out_if.ready) begin
			if (expected_results.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected result: kind %0d code %h index %0d value %h last %0d",
						out_if.result_kind, out_if.type_code, out_if.word_index,
						out_if.word_value, out_if.last);
			end else begin
				want = expected_results.pop_front();
				if (out_if.result_kind !== want.kind || out_if.type_code !== want.code ||
					out_if.word_index !== want.index || out_if.word_value !== want.value ||
					out_if.last !== want.last) begin
					error_count++;
					if (error_count <= 10)
						$display("mismatch: expected kind %0d code %h index %0d value %h ",
							want.kind, want.code, want.index, want.value,
							"last %0d, got kind %0d code %h index %0d value %h last %0d",
							want.last,
							out_if.result_kind, out_if.type_code, out_if.word_index,
							out_if.word_value, out_if.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		in_if.valid    = 1'b0;
		in_if.rx_byte  = 8'd0;
		out_if.ready   = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = REG_SYNC_BYTE;
		cfg_data       = '0;
		error_count    = 0;
		byte_count     = 0;
		stall_cycles   = 0;
		hold_rx_cycles = 0;
		src_idle_pct   = 0;
		snk_idle_pct   = 0;
		sync_code      = SYNC_BYTE_RST;
		sync_run_len   = SYNC_REPEAT_RST;
		resp_code      = RESP_TYPE_RST;
		msg_type       = 16'd0;
		param_code     = 8'd0;
		frame_length   = 16'd0;
		low_byte       = 8'd0;
		end_frame();
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_bad_length();
		test_registers();
		test_midframe_config();
		test_backpressure();
		test_random(160, 19, 77);
		test_random(160, 77, 19);
		test_random(160, 0, 0);

		wait_idle();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		error_count += expected_results.size();
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
